FILE: rtl/snorm_pkg.sv
// Shared constants for the score list normalizer.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package snorm_pkg;

  localparam int DEFAULT_MAX_ITEMS = 64;
  localparam int SCORE_W           = 32;
  localparam int FRAC_W            = 16;

  // Min-max constants: result = (2^16*(r + 99*d) + 50*r) / (100*r).
  localparam int MM_SCALE   = 100;
  localparam int MM_SPAN    = 99;
  localparam int MM_ROUND   = 50;
  localparam int MM_Q_BITS  = 17;
  localparam int MM_W       = 57;
  localparam logic [SCORE_W-1:0] MM_HALF = 32'h0000_8000;

  // Z-score root search produces this many quotient bits.
  localparam int Z_K_BITS = 22;

  localparam logic MODE_MINMAX = 1'b0;
  localparam logic MODE_ZSCORE = 1'b1;

endpackage

FILE: rtl/snorm_front.sv
// Front end of the score list normalizer: accepts score words, stores them,
// tracks the list statistics and queues one job per finished list.
// Depends on snorm_pkg.
module snorm_front #(
  parameter int MAX_ITEMS = snorm_pkg::DEFAULT_MAX_ITEMS,
  localparam int CNT_W = $clog2(MAX_ITEMS + 1),
  localparam int AW    = $clog2(MAX_ITEMS),
  localparam int SUM_W = 31 + CNT_W,
  localparam int JOB_W = SUM_W + CNT_W + 66
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [snorm_pkg::SCORE_W-1:0]   s_axis_tdata,   // raw_score
  input  logic                            s_axis_tlast,
  input  logic                            cfg_wr_en,
  input  logic [0:0]                      cfg_wr_data,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [snorm_pkg::SCORE_W-1:0]   wr_data,
  output logic                            job_push,
  output logic [JOB_W-1:0]                job_data,
  input  logic                            job_full,
  input  logic                            list_done
);
  import snorm_pkg::*;

  logic [CNT_W-1:0]         count, count_next;
  logic signed [SCORE_W-1:0] rmin, rmin_next, rmax, rmax_next, x;
  logic signed [SUM_W-1:0]  rsum, rsum_next;
  logic                     ovf, ovf_next, waiting, norm_mode, room, accept;

  assign s_axis_tready = !waiting && !job_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign x             = signed'(s_axis_tdata);
  assign room          = count < CNT_W'(MAX_ITEMS);

  always_comb begin
    count_next = room ? count + 1'b1 : count;
    rmin_next  = (room && x < rmin) ? x : rmin;
    rmax_next  = (room && x > rmax) ? x : rmax;
    rsum_next  = room ? rsum + SUM_W'(x) : rsum;
    ovf_next   = ovf | !room;
  end

  assign wr_en    = accept && room;
  assign wr_addr  = count[AW-1:0];
  assign wr_data  = s_axis_tdata;
  assign job_push = accept && s_axis_tlast;
  assign job_data = {norm_mode, ovf_next, count_next, rmin_next, rmax_next, rsum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rmin      <= 32'sh7FFF_FFFF;
      rmax      <= 32'sh8000_0000;
      rsum      <= '0;
      ovf       <= 1'b0;
      waiting   <= 1'b0;
      norm_mode <= MODE_MINMAX;
    end else begin
      if (cfg_wr_en) begin
        norm_mode <= cfg_wr_data[0];
      end
      if (accept) begin
        if (s_axis_tlast) begin
          // The list is handed to the back end; start clean for the next one.
          count   <= '0;
          rmin    <= 32'sh7FFF_FFFF;
          rmax    <= 32'sh8000_0000;
          rsum    <= '0;
          ovf     <= 1'b0;
          waiting <= 1'b1;
        end else begin
          count <= count_next;
          rmin  <= rmin_next;
          rmax  <= rmax_next;
          rsum  <= rsum_next;
          ovf   <= ovf_next;
        end
      end
      if (list_done) begin
        waiting <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/snorm_fifo.sv
// Two-entry job queue between the front end and the back end.
// Depends on snorm_pkg only for house consistency of imports.
module snorm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import snorm_pkg::*;

  logic [WIDTH-1:0] slots [2];
  logic             wptr, rptr;
  logic [1:0]       fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= !wptr;
      end
      if (pop && !empty) begin
        rptr <= !rptr;
      end
      fill <= fill + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

endmodule

FILE: rtl/snorm_back.sv
// Back end of the score list normalizer: holds the score memory and runs the
// per-list sequencer (sum of squares, deviation, division, root search).
// Depends on snorm_pkg.
module snorm_back #(
  parameter int MAX_ITEMS = snorm_pkg::DEFAULT_MAX_ITEMS,
  localparam int CNT_W = $clog2(MAX_ITEMS + 1),
  localparam int AW    = $clog2(MAX_ITEMS),
  localparam int SUM_W = 31 + CNT_W,
  localparam int JOB_W = SUM_W + CNT_W + 66
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic [snorm_pkg::SCORE_W-1:0]   wr_data,
  input  logic                            job_empty,
  input  logic [JOB_W-1:0]                job_data,
  output logic                            job_pop,
  output logic                            list_done,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [snorm_pkg::SCORE_W-1:0]   m_axis_tdata,   // norm_score
  output logic                            m_axis_tlast,
  output logic [0:0]                      m_axis_tuser    // dropped_items
);
  import snorm_pkg::*;

  localparam int EW = 32 + CNT_W;          // magnitude of n*x - S
  localparam int QW = 62 + CNT_W;          // sum of squares
  localparam int WW = 108 + 2 * CNT_W;     // root search products
  localparam int MW = MM_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SQ_RD   = 5'd1;
  localparam logic [4:0] S_SQ_MUL  = 5'd2;
  localparam logic [4:0] S_SQ_ADD  = 5'd3;
  localparam logic [4:0] S_DEV_S2  = 5'd4;
  localparam logic [4:0] S_DEV_NQ  = 5'd5;
  localparam logic [4:0] S_DEV_SUB = 5'd6;
  localparam logic [4:0] S_DEV_CHK = 5'd7;
  localparam logic [4:0] S_IT_RD   = 5'd8;
  localparam logic [4:0] S_IT_X    = 5'd9;
  localparam logic [4:0] S_MM_NUM  = 5'd10;
  localparam logic [4:0] S_MM_DIV  = 5'd11;
  localparam logic [4:0] S_Z_E     = 5'd12;
  localparam logic [4:0] S_Z_RHS   = 5'd13;
  localparam logic [4:0] S_Z_A     = 5'd14;
  localparam logic [4:0] S_Z_B     = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;
  localparam logic [4:0] S_MUL     = 5'd17;

  logic [SCORE_W-1:0] mem [MAX_ITEMS];
  logic signed [SCORE_W-1:0] rd_data;

  logic [4:0]               state, mul_ret, bitc;
  logic [CNT_W-1:0]         idx, n;
  logic signed [SCORE_W-1:0] jmin;
  logic signed [SUM_W-1:0]  jsum;
  logic                     jovf, jmode, rng_zero, zzero, eneg;
  logic [SCORE_W-1:0]       rng, dmm, res;
  logic [MW-1:0]            v100, rem;
  logic [MM_Q_BITS-1:0]     quo;
  logic signed [63:0]       sqp;
  logic [QW-1:0]            q_acc;
  logic [WW-1:0]            s2, dev, rhs, pacc, racc, tacc;
  logic [WW-1:0]            mul_a, mul_acc;
  logic [EW-1:0]            mul_b;
  logic signed [EW-1:0]     nx, n_ext, x_ext;
  logic [Z_K_BITS-1:0]      kval;

  // Job fields straight from the queue head.
  logic [CNT_W-1:0]          job_n;
  logic signed [SCORE_W-1:0] job_min, job_max;
  logic [SCORE_W-1:0]        rng_now;
  assign job_n   = job_data[SUM_W+64 +: CNT_W];
  assign job_min = signed'(job_data[SUM_W+32 +: 32]);
  assign job_max = signed'(job_data[SUM_W +: 32]);
  assign rng_now = job_max - job_min;

  // Combinational helpers.
  logic [SUM_W-1:0]        sm;
  logic signed [EW:0]      e_val;
  logic [EW:0]             e_mag;
  logic [MW-1:0]           mm_num, mm_cmp;
  logic                    mm_take, z_take, out_free, last_item;
  logic [MM_Q_BITS-1:0]    quo_next;
  logic [WW-1:0]           z_cand;
  logic [Z_K_BITS-1:0]     kval_next;

  assign sm    = jsum[SUM_W-1] ? SUM_W'(-jsum) : SUM_W'(jsum);
  assign n_ext = EW'($signed({1'b0, n}));
  assign x_ext = EW'(rd_data);
  assign e_val = $signed({nx[EW-1], nx}) - (EW+1)'(jsum);
  assign e_mag = e_val[EW] ? (EW+1)'(-e_val) : (EW+1)'(e_val);

  assign mm_num = ((MW'(rng) + MW'(dmm) * MW'(MM_SPAN)) << FRAC_W) +
                  MW'(rng) * MW'(MM_ROUND);
  assign mm_cmp   = v100 << bitc;
  assign mm_take  = rem >= mm_cmp;
  assign quo_next = quo | (mm_take ? (MM_Q_BITS'(1) << bitc) : '0);

  assign z_cand    = tacc + (dev << {bitc, 1'b0});
  assign z_take    = z_cand <= rhs;
  assign kval_next = kval | (z_take ? (Z_K_BITS'(1) << bitc) : '0);

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign last_item = idx == n - 1'b1;
  assign job_pop   = (state == S_IDLE) && !job_empty;
  assign list_done = (state == S_OUT) && out_free && last_item;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= signed'(mem[idx[AW-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A new word is loaded when the register is free; otherwise a taken word clears it.
      m_axis_tvalid <= (state == S_OUT && out_free) || (m_axis_tvalid && !m_axis_tready);
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            n        <= job_n;
            jmin     <= job_min;
            jsum     <= signed'(job_data[SUM_W-1:0]);
            jovf     <= job_data[JOB_W-2];
            jmode    <= job_data[JOB_W-1];
            rng      <= rng_now;
            rng_zero <= rng_now == '0;
            v100     <= MW'(rng_now) * MW'(MM_SCALE);
            zzero    <= job_n <= CNT_W'(1);
            idx      <= '0;
            q_acc    <= '0;
            if (job_data[JOB_W-1] == MODE_ZSCORE && job_n > CNT_W'(1)) begin
              state <= S_SQ_RD;
            end else begin
              state <= S_IT_RD;
            end
          end
        end
        S_SQ_RD: begin
          state <= S_SQ_MUL;
        end
        S_SQ_MUL: begin
          sqp   <= rd_data * rd_data;
          state <= S_SQ_ADD;
        end
        S_SQ_ADD: begin
          q_acc <= q_acc + QW'(sqp);
          if (last_item) begin
            idx   <= '0;
            state <= S_DEV_S2;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ_RD;
          end
        end
        S_DEV_S2: begin
          mul_a   <= WW'(sm);
          mul_b   <= EW'(sm);
          mul_acc <= '0;
          mul_ret <= S_DEV_NQ;
          state   <= S_MUL;
        end
        S_DEV_NQ: begin
          s2      <= mul_acc;
          mul_a   <= WW'(q_acc);
          mul_b   <= EW'(n);
          mul_acc <= '0;
          mul_ret <= S_DEV_SUB;
          state   <= S_MUL;
        end
        S_DEV_SUB: begin
          dev   <= mul_acc - s2;
          state <= S_DEV_CHK;
        end
        S_DEV_CHK: begin
          zzero <= dev == '0;
          state <= S_IT_RD;
        end
        S_MUL: begin
          // Shift-and-add multiply, one multiplier bit per cycle.
          if (mul_b == '0) begin
            state <= mul_ret;
          end else begin
            if (mul_b[0]) begin
              mul_acc <= mul_acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end
        end
        S_IT_RD: begin
          state <= S_IT_X;
        end
        S_IT_X: begin
          if (jmode == MODE_MINMAX) begin
            if (rng_zero) begin
              res   <= MM_HALF;
              state <= S_OUT;
            end else begin
              dmm   <= rd_data - jmin;
              state <= S_MM_NUM;
            end
          end else if (zzero) begin
            res   <= '0;
            state <= S_OUT;
          end else begin
            nx    <= n_ext * x_ext;
            state <= S_Z_E;
          end
        end
        S_MM_NUM: begin
          rem   <= mm_num;
          quo   <= '0;
          bitc  <= 5'(MM_Q_BITS - 1);
          state <= S_MM_DIV;
        end
        S_MM_DIV: begin
          if (mm_take) begin
            rem <= rem - mm_cmp;
          end
          quo <= quo_next;
          if (bitc == '0) begin
            res   <= SCORE_W'(quo_next);
            state <= S_OUT;
          end else begin
            bitc <= bitc - 1'b1;
          end
        end
        S_Z_E: begin
          eneg    <= e_val[EW];
          mul_a   <= WW'(e_mag);
          mul_b   <= e_mag[EW-1:0];
          mul_acc <= '0;
          mul_ret <= S_Z_RHS;
          state   <= S_MUL;
        end
        S_Z_RHS: begin
          rhs   <= mul_acc << 32;
          pacc  <= '0;
          racc  <= '0;
          kval  <= '0;
          bitc  <= 5'(Z_K_BITS - 1);
          state <= S_Z_A;
        end
        S_Z_A: begin
          // pacc holds k*k*D and racc holds k*D for the bits settled so far.
          tacc  <= pacc + (racc << (bitc + 5'd1));
          state <= S_Z_B;
        end
        S_Z_B: begin
          if (z_take) begin
            pacc <= z_cand;
            racc <= racc + (dev << bitc);
          end
          kval <= kval_next;
          if (bitc == '0) begin
            res   <= eneg ? SCORE_W'(0) - SCORE_W'(kval_next) : SCORE_W'(kval_next);
            state <= S_OUT;
          end else begin
            bitc  <= bitc - 1'b1;
            state <= S_Z_A;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tdata    <= res;
            m_axis_tlast    <= last_item;
            m_axis_tuser[0] <= jovf;
            if (last_item) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_IT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/score_list_normalizer.sv
// Top level of the score list normalizer.
// Depends on snorm_pkg, snorm_front, snorm_fifo and snorm_back.
//
// Usage: score words (signed Q16.16) enter on the s_axis channel, one per
// cycle while s_axis_tready is high; s_axis_tlast marks the last score of a
// list. Up to MAX_ITEMS scores are stored; later ones are discarded and the
// list's results carry tuser set. After the last word the input stalls until
// the list's results have been produced, and then one normalized word per
// stored score leaves on m_axis in arrival order, tlast on the final one.
// cfg_wr_en/cfg_wr_data select the mode (0 min-max, 1 z-score) between lists.
//
// Words load one per cycle while s_axis_tready is high. Results are paced
// by the back-end sequencer, one result at a time: min-max runs a 17-bit
// restoring divider, one quotient bit per cycle (skipped for a zero range).
// Z-score first runs a sum-of-squares pass that reads, squares and adds each
// item and two shift-add multiplies, then per result a shift-add square of
// |n*x - S| (one bit per cycle) and a 22-bit root search, one bit at a time.
// A stalled receiver holds the output word; the sequencer waits on it.
// Reset clears the list state, the job queue, the mode and the output valid.
module score_list_normalizer #(
  parameter int MAX_ITEMS = snorm_pkg::DEFAULT_MAX_ITEMS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [snorm_pkg::SCORE_W-1:0] s_axis_tdata,   // [31:0] raw_score
  input  logic                          s_axis_tlast,   // is_final
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [snorm_pkg::SCORE_W-1:0] m_axis_tdata,   // [31:0] norm_score
  output logic                          m_axis_tlast,   // end_of_list
  output logic [0:0]                    m_axis_tuser,   // [0] dropped_items
  input  logic                          cfg_wr_en,
  input  logic [0:0]                    cfg_wr_data     // [0] norm_mode
);
  import snorm_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int SUM_W = 31 + CNT_W;
  localparam int JOB_W = SUM_W + CNT_W + 66;

  logic               wr_en, job_push, job_full, job_pop, job_empty, list_done;
  logic [AW-1:0]      wr_addr;
  logic [SCORE_W-1:0] wr_data;
  logic [JOB_W-1:0]   job_in, job_out;

  // The front end stores words and builds one job per list.
  snorm_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .job_push(job_push), .job_data(job_in), .job_full(job_full),
    .list_done(list_done)
  );

  // Jobs wait here so each side can stall on its own.
  snorm_fifo #(.WIDTH(JOB_W)) u_jobs (
    .clk(clk), .rst(rst),
    .push(job_push), .din(job_in), .full(job_full),
    .pop(job_pop), .dout(job_out), .empty(job_empty)
  );

  // The back end owns the score memory and produces the results.
  snorm_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .job_empty(job_empty), .job_data(job_out), .job_pop(job_pop),
    .list_done(list_done),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

endmodule

FILE: rtl/snorm_checker.sv
// Port-level checks for the score list normalizer, bound to the top level.
// Depends on snorm_pkg and score_list_normalizer.
module snorm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [snorm_pkg::SCORE_W-1:0] s_axis_tdata,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [snorm_pkg::SCORE_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic [0:0]                    m_axis_tuser,
  input logic                          cfg_wr_en,
  input logic [0:0]                    cfg_wr_data
);
  import snorm_pkg::*;

  // Reset leaves no result word pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // Once the last word of a list is taken, loading stops.
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted right after end of list");

  // While a list is still being emitted, no new word is taken.
  a_no_load_mid_list: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a result list");

endmodule

bind score_list_normalizer snorm_checker u_snorm_checker (.*);
